// File: rtl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types and constants of the MQTT packet framer: packet kinds, header
// byte values, and the job record that the front hands to the back.
// ----------------------------------------------------------------------------
package mpf_pkg;

   typedef enum logic [1:0] {
      KIND_CONNECT   = 2'd0,
      KIND_PUBLISH   = 2'd1,
      KIND_SUBSCRIBE = 2'd2,
      KIND_INVALID   = 2'd3
   } kind_type;

   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_ALIVE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECT_FLAGS = 1'b1;

   localparam logic [15:0] KEEP_ALIVE_RESET    = 16'hFFFF;
   localparam logic [7:0]  CONNECT_FLAGS_RESET = 8'h02;
   localparam logic [15:0] PACKET_ID_RESET     = 16'h0001;

   localparam logic [7:0] FH_CONNECT   = 8'h10;
   localparam logic [7:0] FH_PUBLISH   = 8'h30;
   localparam logic [7:0] FH_SUBSCRIBE = 8'h82;
   localparam logic [7:0] PROTO_LEN    = 8'h04;
   localparam logic [7:0] PROTO_LEVEL  = 8'h04;
   localparam logic [7:0] SUB_QOS_BYTE = 8'h01;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;
   localparam logic [7:0] CHAR_M       = 8'h4D;
   localparam logic [7:0] CHAR_Q       = 8'h51;
   localparam logic [7:0] CHAR_T       = 8'h54;

   localparam logic [9:0] REM_CONNECT   = 10'd12;
   localparam logic [9:0] REM_PUBLISH   = 10'd2;
   localparam logic [9:0] REM_SUBSCRIBE = 10'd5;
   localparam logic [9:0] REM_PUB_ID    = 10'd2;
   localparam logic [9:0] REM_ONE_BYTE  = 10'd127;

   localparam logic [3:0] HDR_LEN_CONNECT   = 4'd14;
   localparam logic [3:0] HDR_LEN_PUBLISH   = 4'd4;
   localparam logic [3:0] HDR_LEN_SUBSCRIBE = 4'd6;

   localparam logic [1:0] TAIL_LEN_ID  = 2'd2;
   localparam logic [1:0] TAIL_LEN_QOS = 2'd1;

   // one accepted item, classified: everything the back needs to emit its bytes
   typedef struct packed {
      logic        first;
      kind_type    kind;
      logic [1:0]  qos;
      logic [7:0]  rem_byte;
      logic [7:0]  str_len;
      logic [15:0] pkt_id;
      logic [7:0]  data;
      logic        tail_pre;
      logic        pkt_end;
      logic        ovf;
      logic [3:0]  num_bytes;
   } job_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       length_overflow;
   } rsp_type;

   function automatic logic [3:0] hdr_len_of(input logic first, input kind_type kind);
      logic [3:0] len;
      len = 4'd0;
      if (first) begin
         case (kind)
            KIND_CONNECT:   len = HDR_LEN_CONNECT;
            KIND_PUBLISH:   len = HDR_LEN_PUBLISH;
            KIND_SUBSCRIBE: len = HDR_LEN_SUBSCRIBE;
            default:        len = 4'd0;
         endcase
      end
      return len;
   endfunction

   function automatic logic [1:0] tail_len_of(input kind_type kind, input logic [1:0] qos);
      logic [1:0] len;
      len = 2'd0;
      case (kind)
         KIND_PUBLISH:   len = (qos != 2'd0) ? TAIL_LEN_ID : 2'd0;
         KIND_SUBSCRIBE: len = TAIL_LEN_QOS;
         default:        len = 2'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/mpf_front.sv
// ----------------------------------------------------------------------------
// mpf_front
// Accepts input items, tracks packet progress and the packet identifier, and turns
// each item into one job record for the byte serializer; an INVALID first item is dropped.
// ----------------------------------------------------------------------------
module mpf_front
   import mpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_op,
   input  logic [7:0] req_string_len,
   input  logic [7:0] req_msg_len,
   input  logic [1:0] req_qos,
   input  logic [7:0] req_data_byte,
   input  logic       job_full,
   output logic       job_push,
   output job_type    job
);

   logic        phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [1:0]  qos_ff, qos_in;
   logic        ovf_ff, ovf_in;
   logic [7:0]  str_left_ff, str_left_in;
   logic [7:0]  msg_left_ff, msg_left_in;
   logic [15:0] pkt_num_ff, pkt_num_in;

   logic        first;
   logic        accept;
   kind_type    kind;
   logic [1:0]  qos;
   logic [7:0]  msg_len_eff;
   logic [7:0]  str_cur, msg_cur;
   logic [9:0]  rem;
   logic        ovf;
   logic [1:0]  tail_len;
   logic        tail_pre, tail_post, data_en, uses_id, pkt_end;
   logic [7:0]  str_next, msg_next;

   assign req_full = job_full;
   assign first    = !phase_ff;
   assign accept   = req_push && !job_full;

   always_comb begin
      kind        = first ? kind_type'(req_op) : kind_ff;
      qos         = first ? req_qos : qos_ff;
      msg_len_eff = (kind_type'(req_op) == KIND_PUBLISH) ? req_msg_len : 8'd0;
      str_cur     = first ? req_string_len : str_left_ff;
      msg_cur     = first ? msg_len_eff : msg_left_ff;

      case (kind_type'(req_op))
         KIND_CONNECT:   rem = REM_CONNECT + {2'b0, req_string_len};
         KIND_PUBLISH:   rem = REM_PUBLISH + {2'b0, req_string_len} + {2'b0, req_msg_len}
                               + ((req_qos != 2'd0) ? REM_PUB_ID : 10'd0);
         KIND_SUBSCRIBE: rem = REM_SUBSCRIBE + {2'b0, req_string_len};
         default:        rem = 10'd0;
      endcase
      ovf = first ? (rem > REM_ONE_BYTE) : ovf_ff;

      tail_len  = tail_len_of(kind, qos);
      tail_pre  = first && (str_cur == 8'd0) && (tail_len != 2'd0);
      tail_post = (str_cur == 8'd1) && (tail_len != 2'd0);
      data_en   = (str_cur != 8'd0) || (msg_cur != 8'd0);
      str_next  = (str_cur != 8'd0) ? str_cur - 8'd1 : 8'd0;
      msg_next  = ((str_cur == 8'd0) && (msg_cur != 8'd0)) ? msg_cur - 8'd1 : msg_cur;
      pkt_end   = (str_next == 8'd0) && (msg_next == 8'd0);
      uses_id   = (first && (kind == KIND_SUBSCRIBE))
                  || ((kind == KIND_PUBLISH) && (qos != 2'd0) && (tail_pre || tail_post));

      job_push = accept && !(first && (kind_type'(req_op) == KIND_INVALID));

      job.first     = first;
      job.kind      = kind;
      job.qos       = qos;
      job.rem_byte  = rem[7:0];
      job.str_len   = req_string_len;
      job.pkt_id    = pkt_num_ff;
      job.data      = req_data_byte;
      job.tail_pre  = tail_pre;
      job.pkt_end   = pkt_end;
      job.ovf       = ovf;
      job.num_bytes = hdr_len_of(first, kind)
                      + ((tail_pre || tail_post) ? {2'b0, tail_len} : 4'd0)
                      + {3'b0, data_en};

      phase_in    = phase_ff;
      kind_in     = kind_ff;
      qos_in      = qos_ff;
      ovf_in      = ovf_ff;
      str_left_in = str_left_ff;
      msg_left_in = msg_left_ff;
      pkt_num_in  = pkt_num_ff;
      if (job_push) begin
         phase_in    = !pkt_end;
         kind_in     = kind;
         qos_in      = qos;
         ovf_in      = ovf;
         str_left_in = str_next;
         msg_left_in = msg_next;
         pkt_num_in  = uses_id ? pkt_num_ff + 16'd1 : pkt_num_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 1'b0;
         kind_ff     <= KIND_CONNECT;
         qos_ff      <= 2'd0;
         ovf_ff      <= 1'b0;
         str_left_ff <= 8'd0;
         msg_left_ff <= 8'd0;
         pkt_num_ff  <= PACKET_ID_RESET;
      end else begin
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         qos_ff      <= qos_in;
         ovf_ff      <= ovf_in;
         str_left_ff <= str_left_in;
         msg_left_ff <= msg_left_in;
         pkt_num_ff  <= pkt_num_in;
      end
   end

endmodule

// File: rtl/mpf_queue.sv
// ----------------------------------------------------------------------------
// mpf_queue
// Small job queue between the front and the byte serializer.
// ----------------------------------------------------------------------------
module mpf_queue
   import mpf_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == DEPTH_CNT);
   assign empty    = (cnt_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: rtl/mpf_back.sv
// ----------------------------------------------------------------------------
// mpf_back
// Byte serializer: walks the head job into a two-entry result buffer, one byte
// per cycle while it has room (header, then ID or QoS tail and data in either order). Holds the CSRs.
// ----------------------------------------------------------------------------
module mpf_back
   import mpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  job_empty,
   input  job_type               job,
   output logic                  job_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_packet_end,
   output logic                  rsp_length_overflow
);

   logic [15:0] keep_alive_ff;
   logic [7:0]  flags_ff;
   logic [3:0]  idx_ff, idx_in;
   rsp_type     buf_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;

   logic        out_pop, space, emit, last;
   logic [3:0]  hdr_len, rel, tail_idx;
   logic [1:0]  tail_len;
   logic [7:0]  hdr_byte, tail_byte;
   rsp_type     item;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_alive_ff <= KEEP_ALIVE_RESET;
         flags_ff      <= CONNECT_FLAGS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEEP_ALIVE:    keep_alive_ff <= csr_wdata;
            CSR_CONNECT_FLAGS: flags_ff      <= csr_wdata[7:0];
            default:           flags_ff      <= flags_ff;
         endcase
      end
   end

   always_comb begin
      hdr_byte = ZERO_BYTE;
      case (job.kind)
         KIND_CONNECT: begin
            case (idx_ff)
               4'd0:    hdr_byte = FH_CONNECT;
               4'd1:    hdr_byte = job.rem_byte;
               4'd2:    hdr_byte = ZERO_BYTE;
               4'd3:    hdr_byte = PROTO_LEN;
               4'd4:    hdr_byte = CHAR_M;
               4'd5:    hdr_byte = CHAR_Q;
               4'd6:    hdr_byte = CHAR_T;
               4'd7:    hdr_byte = CHAR_T;
               4'd8:    hdr_byte = PROTO_LEVEL;
               4'd9:    hdr_byte = flags_ff;
               4'd10:   hdr_byte = keep_alive_ff[15:8];
               4'd11:   hdr_byte = keep_alive_ff[7:0];
               4'd12:   hdr_byte = ZERO_BYTE;
               default: hdr_byte = job.str_len;
            endcase
         end
         KIND_PUBLISH: begin
            case (idx_ff)
               4'd0:    hdr_byte = FH_PUBLISH | {5'b0, job.qos, 1'b0};
               4'd1:    hdr_byte = job.rem_byte;
               4'd2:    hdr_byte = ZERO_BYTE;
               default: hdr_byte = job.str_len;
            endcase
         end
         default: begin
            case (idx_ff)
               4'd0:    hdr_byte = FH_SUBSCRIBE;
               4'd1:    hdr_byte = job.rem_byte;
               4'd2:    hdr_byte = job.pkt_id[15:8];
               4'd3:    hdr_byte = job.pkt_id[7:0];
               4'd4:    hdr_byte = ZERO_BYTE;
               default: hdr_byte = job.str_len;
            endcase
         end
      endcase

      hdr_len  = hdr_len_of(job.first, job.kind);
      tail_len = tail_len_of(job.kind, job.qos);
      rel      = idx_ff - hdr_len;
      tail_idx = job.tail_pre ? rel : rel - 4'd1;
      if (job.kind == KIND_SUBSCRIBE) begin
         tail_byte = SUB_QOS_BYTE;
      end else begin
         tail_byte = tail_idx[0] ? job.pkt_id[7:0] : job.pkt_id[15:8];
      end

      if (idx_ff < hdr_len) begin
         item.out_byte = hdr_byte;
      end else if (job.tail_pre) begin
         item.out_byte = (rel < {2'b0, tail_len}) ? tail_byte : job.data;
      end else begin
         item.out_byte = (rel == 4'd0) ? job.data : tail_byte;
      end
      last                 = (idx_ff == job.num_bytes - 4'd1);
      item.packet_end      = job.pkt_end && last;
      item.length_overflow = job.ovf;
   end

   assign out_pop   = rsp_pop && (cnt_ff != 2'd0);
   assign space     = (cnt_ff != 2'd2) || out_pop;
   assign emit      = !job_empty && space;
   assign job_pop   = emit && last;
   assign rsp_empty = (cnt_ff == 2'd0);

   assign rsp_out_byte        = buf_ff[rd_ptr_ff].out_byte;
   assign rsp_packet_end      = buf_ff[rd_ptr_ff].packet_end;
   assign rsp_length_overflow = buf_ff[rd_ptr_ff].length_overflow;

   always_comb begin
      idx_in = idx_ff;
      if (emit) begin
         idx_in = last ? 4'd0 : idx_ff + 4'd1;
      end
      case ({emit, out_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         buf_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= 4'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         idx_ff    <= idx_in;
         wr_ptr_ff <= wr_ptr_ff ^ emit;
         rd_ptr_ff <= rd_ptr_ff ^ out_pop;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: rtl/mqtt_packet_framer.sv
// ----------------------------------------------------------------------------
// mqtt_packet_framer
// Frames MQTT 3.1.1 CONNECT, PUBLISH and SUBSCRIBE packets into a byte stream.
//
//   channel  ports                      moves
//   req      req_push / req_full        one string or message byte (+ header info)
//   rsp      rsp_pop / rsp_empty        one framed packet byte
//   csr      csr_we / csr_index         keep-alive, connect flags
//
// The serializer emits one byte per cycle while a job waits and the result
// buffer has room. The first item of a packet carries 4, 6 or 14 header bytes
// plus up to 3 more (data and tail); a later item carries one byte, two when it
// closes a SUBSCRIBE topic and three when it closes a topic with a packet
// identifier. Input keeps flowing until JOB_DEPTH jobs wait. Reset is synchronous
// and empties both queues. Backpressure on rsp fills the two-entry result buffer,
// then the job queue, then raises req_full.
// ----------------------------------------------------------------------------
module mqtt_packet_framer
   import mpf_pkg::*;
#(
   parameter int JOB_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_op,
   input  logic [7:0]            req_string_len,
   input  logic [7:0]            req_msg_len,
   input  logic [1:0]            req_qos,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_packet_end,
   output logic                  rsp_length_overflow,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_head;

   mpf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_string_len (req_string_len),
      .req_msg_len    (req_msg_len),
      .req_qos        (req_qos),
      .req_data_byte  (req_data_byte),
      .job_full       (job_full),
      .job_push       (job_push),
      .job            (job_in)
   );

   mpf_queue #(.DEPTH(JOB_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .full     (job_full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (job_head)
   );

   mpf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .job_empty           (job_empty),
      .job                 (job_head),
      .job_pop             (job_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_packet_end      (rsp_packet_end),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule

// File: rtl/mpf_checker.sv
// ----------------------------------------------------------------------------
// mpf_checker
// Port-level checks of the MQTT packet framer, bound to the top level.
// ----------------------------------------------------------------------------
module mpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_packet_end,
   input logic       rsp_length_overflow
);

   logic mid_ff, ovf_ff, rsp_xfer;

   assign rsp_xfer = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (rsp_xfer) begin
         mid_ff <= !rsp_packet_end;
         ovf_ff <= rsp_length_overflow;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)
         && $stable(rsp_packet_end) && $stable(rsp_length_overflow)))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && mid_ff) |-> (rsp_length_overflow == ovf_ff))
      else $error("length overflow flag changed inside a packet");

endmodule

bind mqtt_packet_framer mpf_checker u_mpf_checker (.*);
